// ----- hw/rtl/fpd_pkg.sv -----
// Shared types, constants and helpers for the FSK period demodulator receiver.
`timescale 1ns / 1ps
`default_nettype none
package fpd_pkg;

  // Receive FIFO geometry; the ring holds FIFO_DEPTH-1 bytes
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam int COUNT_W    = 4;

  // Request commands
  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_LOW_PERIOD_MAX  = 3'd0;
  localparam logic [2:0] REG_LOW_PERIOD_MIN  = 3'd1;
  localparam logic [2:0] REG_HIGH_PERIOD_MAX = 3'd2;
  localparam logic [2:0] REG_BIT_TICKS       = 3'd3;
  localparam logic [2:0] REG_START_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_MIN_PERIOD      = 3'd5;
  localparam logic [2:0] REG_AVERAGE_ENABLE  = 3'd6;

  // Frame phases: start, data 1..8, stop, idle
  localparam logic [3:0] PHASE_START = 4'd0;
  localparam logic [3:0] PHASE_DATA1 = 4'd1;
  localparam logic [3:0] PHASE_DATA8 = 4'd8;
  localparam logic [3:0] PHASE_STOP  = 4'd9;
  localparam logic [3:0] PHASE_IDLE  = 4'd15;

  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef struct packed {
    logic [7:0] low_period_max;
    logic [7:0] low_period_min;
    logic [7:0] high_period_max;
    logic [7:0] bit_ticks;
    logic [7:0] start_threshold;
    logic [7:0] min_period;
    logic       average_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] last_edge_time;
    logic [7:0] smoothed_period;
    logic [7:0] low_tone_sum;
    logic [7:0] high_tone_sum;
    logic [3:0] frame_phase;
    logic [7:0] shift_byte;
    logic [7:0] sample_compare;
  } rx_state_t;

  typedef struct packed {
    logic push;
    logic byte_done;
    logic framing_error;
    logic overrun_error;
  } sample_flags_t;

  // Default thresholds after reset
  localparam cfg_t CFG_RESET = '{
    low_period_max:  8'd56,
    low_period_min:  8'd43,
    high_period_max: 8'd39,
    bit_ticks:       8'd204,
    start_threshold: 8'd102,
    min_period:      8'd4,
    average_enable:  1'b0
  };

  // Receiver state after reset: sums cleared, sampler idle
  localparam rx_state_t RX_STATE_RESET = '{
    last_edge_time:  8'h00,
    smoothed_period: 8'h00,
    low_tone_sum:    8'h00,
    high_tone_sum:   8'h00,
    frame_phase:     PHASE_IDLE,
    shift_byte:      8'h00,
    sample_compare:  8'h00
  };

  function automatic logic [FIFO_AW-1:0] fifo_next(input logic [FIFO_AW-1:0] ptr);
    if (ptr == FIFO_AW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fpd_edge.sv -----
// Edge path: period measure, glitch/long rejection, smoothing, tone sums, start detect.
`timescale 1ns / 1ps
`default_nettype none
module fpd_edge (
  input  fpd_pkg::cfg_t      cfg_i,
  input  fpd_pkg::rx_state_t state_i,
  input  logic [7:0]         timer_i,
  output fpd_pkg::rx_state_t state_o
);
  import fpd_pkg::*;

  logic [7:0] period;
  logic [7:0] smoothed;
  logic [7:0] low_sum;

  always_comb begin
    period   = timer_i - state_i.last_edge_time;
    smoothed = cfg_i.average_enable
             ? ((period >> 1) + (period >> 2) + (state_i.smoothed_period >> 2))
             : period;
    low_sum  = state_i.low_tone_sum + smoothed;
    state_o  = state_i;
    if (period >= cfg_i.min_period) begin
      state_o.last_edge_time = timer_i;
      if (period <= cfg_i.low_period_max) begin
        state_o.smoothed_period = smoothed;
        if (smoothed >= cfg_i.low_period_min) begin
          state_o.low_tone_sum = low_sum;
          if (state_i.frame_phase == PHASE_IDLE && low_sum >= cfg_i.start_threshold) begin
            state_o.frame_phase    = PHASE_START;
            state_o.high_tone_sum  = '0;
            state_o.shift_byte     = '0;
            state_o.sample_compare = timer_i + cfg_i.bit_ticks - low_sum;
          end
        end else if (smoothed <= cfg_i.high_period_max) begin
          if (state_i.frame_phase == PHASE_IDLE) begin
            state_o.low_tone_sum  = '0;
            state_o.high_tone_sum = '0;
          end else begin
            state_o.high_tone_sum = state_i.high_tone_sum + smoothed;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fpd_sample.sv -----
// Bit sampler: tone decision and start/data/stop frame sequencing.
`timescale 1ns / 1ps
`default_nettype none
module fpd_sample (
  input  fpd_pkg::cfg_t          cfg_i,
  input  fpd_pkg::rx_state_t     state_i,
  input  logic                   fifo_full_i,
  output fpd_pkg::rx_state_t     state_o,
  output fpd_pkg::sample_flags_t flags_o
);
  import fpd_pkg::*;

  logic high;

  always_comb begin
    state_o = state_i;
    flags_o = '0;
    state_o.sample_compare = state_i.sample_compare + cfg_i.bit_ticks;
    high = state_i.high_tone_sum > state_i.low_tone_sum;
    if (high) begin
      state_o.high_tone_sum = '0;
    end else begin
      state_o.low_tone_sum = '0;
    end

    if (state_i.frame_phase == PHASE_START) begin
      state_o.frame_phase = high ? PHASE_IDLE : PHASE_DATA1;
    end else if (state_i.frame_phase inside {[PHASE_DATA1:PHASE_DATA8]}) begin
      state_o.shift_byte  = (state_i.shift_byte >> 1) | (high ? MSB_MASK : 8'h00);
      state_o.frame_phase = state_i.frame_phase + 4'd1;
    end else begin
      // stop bit, or a stray phase code: either way the frame ends here
      state_o.frame_phase = PHASE_IDLE;
      if (state_i.frame_phase == PHASE_STOP) begin
        if (!high) begin
          flags_o.framing_error = 1'b1;
        end else if (fifo_full_i) begin
          flags_o.overrun_error = 1'b1;
        end else begin
          flags_o.push      = 1'b1;
          flags_o.byte_done = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fpd_fifo.sv -----
// Receive ring FIFO; one slot stays empty so it holds FIFO_DEPTH-1 bytes.
`timescale 1ns / 1ps
`default_nettype none
module fpd_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [7:0]                  data_i,
  input  logic                        pop_i,
  output logic [7:0]                  rd_data_o,
  output logic                        full_o,
  output logic                        empty_o,
  output logic [fpd_pkg::COUNT_W-1:0] count_o
);
  import fpd_pkg::*;

  logic [7:0]         store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_q, head_d;
  logic [FIFO_AW-1:0] tail_q, tail_d;
  logic [FIFO_CW-1:0] count;

  assign rd_data_o = store_q[head_q];
  assign empty_o   = head_q == tail_q;
  assign full_o    = fifo_next(tail_q) == head_q;

  always_comb begin
    head_d = pop_i  ? fifo_next(head_q) : head_q;
    tail_d = push_i ? fifo_next(tail_q) : tail_q;
    count  = {1'b0, tail_d} - {1'b0, head_d};
    if (tail_d < head_d) begin
      count = count + FIFO_CW'(FIFO_DEPTH);
    end
    count_o = COUNT_W'(count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[tail_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fsk_period_demodulator_uart_rx.sv -----
// Top level of the FSK period demodulator with asynchronous byte receiver.
//
// Requests come in on the in channel (in_valid_i/in_ready_o) carrying
// command_i and timer_value_i: a comparator edge, a timer tick, a read of
// one received byte, or a no-op. Every accepted request yields exactly one
// result on the out channel (out_valid_o/out_ready_i): the popped byte if
// any, the FIFO fill after the request, pulses for a stored byte, a framing
// error or an overrun, and the receiving flag.
// The result register loads on the accepting edge. Throughput is one
// request per cycle while results are taken; the whole update (8-bit period
// subtract, tone-sum add and compares, FIFO pointer step) is combinational
// between the input ports and the result register.
// While the receiver stalls, a held result blocks only until it is taken:
// in_ready_o stays high whenever the result register is empty or is being
// drained in the same cycle.
// Reset (rst_ni low, asynchronous) restores the default thresholds, empties
// the FIFO, clears the tone sums and puts the frame sampler in idle.
// Configuration writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at
// the next edge and should only be issued while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module fsk_period_demodulator_uart_rx (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_addr_i,
  input  logic [7:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [7:0]                  timer_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        read_valid_o,
  output logic [7:0]                  read_data_o,
  output logic [fpd_pkg::COUNT_W-1:0] fifo_count_o,
  output logic                        byte_done_o,
  output logic                        framing_error_o,
  output logic                        overrun_error_o,
  output logic                        receiving_o
);
  import fpd_pkg::*;

  cfg_t          cfg_q;
  rx_state_t     state_q, state_d;
  rx_state_t     edge_state, sample_state;
  sample_flags_t sample_flags, flags;

  logic                accept;
  logic                do_sample;
  logic                pop;
  logic [7:0]          fifo_rd_data;
  logic                fifo_full, fifo_empty;
  logic [COUNT_W-1:0]  fifo_count;

  logic                out_valid_q;
  logic                read_valid_q;
  logic [7:0]          read_data_q;
  logic [COUNT_W-1:0]  fifo_count_q;
  logic                byte_done_q, framing_error_q, overrun_error_q, receiving_q;

  // Result register frees up when empty or drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LOW_PERIOD_MAX:  cfg_q.low_period_max  <= cfg_wdata_i;
        REG_LOW_PERIOD_MIN:  cfg_q.low_period_min  <= cfg_wdata_i;
        REG_HIGH_PERIOD_MAX: cfg_q.high_period_max <= cfg_wdata_i;
        REG_BIT_TICKS:       cfg_q.bit_ticks       <= cfg_wdata_i;
        REG_START_THRESHOLD: cfg_q.start_threshold <= cfg_wdata_i;
        REG_MIN_PERIOD:      cfg_q.min_period      <= cfg_wdata_i;
        REG_AVERAGE_ENABLE:  cfg_q.average_enable  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  fpd_edge u_edge (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .timer_i (timer_value_i),
    .state_o (edge_state)
  );

  fpd_sample u_sample (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .fifo_full_i (fifo_full),
    .state_o     (sample_state),
    .flags_o     (sample_flags)
  );

  // A tick samples only while a frame runs and the timer hits the compare
  assign do_sample = accept && command_i == CMD_TICK
                  && state_q.frame_phase != PHASE_IDLE
                  && timer_value_i == state_q.sample_compare;
  assign pop       = accept && command_i == CMD_READ && !fifo_empty;
  assign flags     = do_sample ? sample_flags : '0;

  always_comb begin
    state_d = state_q;
    if (accept && command_i == CMD_EDGE) begin
      state_d = edge_state;
    end else if (do_sample) begin
      state_d = sample_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RX_STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  fpd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (flags.push),
    .data_i    (state_q.shift_byte),
    .pop_i     (pop),
    .rd_data_o (fifo_rd_data),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty),
    .count_o   (fifo_count)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_valid_q    <= pop;
      read_data_q     <= pop ? fifo_rd_data : 8'h00;
      fifo_count_q    <= fifo_count;
      byte_done_q     <= flags.byte_done;
      framing_error_q <= flags.framing_error;
      overrun_error_q <= flags.overrun_error;
      receiving_q     <= state_d.frame_phase != PHASE_IDLE;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_valid_o    = read_valid_q;
  assign read_data_o     = read_data_q;
  assign fifo_count_o    = fifo_count_q;
  assign byte_done_o     = byte_done_q;
  assign framing_error_o = framing_error_q;
  assign overrun_error_o = overrun_error_q;
  assign receiving_o     = receiving_q;

endmodule
`default_nettype wire

// ----- hw/rtl/fpd_checker.sv -----
// Port-level checker for the FSK receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        read_valid_o,
  input logic [7:0]                  read_data_o,
  input logic                        byte_done_o,
  input logic                        framing_error_o,
  input logic                        overrun_error_o
);
  import fpd_pkg::*;

  // A held result is not dropped before it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted request shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // A result carries at most one of stored, framing error or overrun
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({byte_done_o, framing_error_o, overrun_error_o}) <= 1)
    else $error("more than one frame outcome");

  // A read and a frame outcome never share one request
  a_read_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> !byte_done_o && !framing_error_o && !overrun_error_o)
    else $error("read result carries a frame outcome");

  // An empty read returns zero data
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == 8'h00)
    else $error("read data nonzero without a popped byte");

endmodule

bind fsk_period_demodulator_uart_rx fpd_checker u_fpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_valid_o    (read_valid_o),
  .read_data_o     (read_data_o),
  .byte_done_o     (byte_done_o),
  .framing_error_o (framing_error_o),
  .overrun_error_o (overrun_error_o)
);
`default_nettype wire
